[rtl/ndpf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ndpf_pkg
// Shared constants, types and helpers of the near-duplicate point filter.
// ----------------------------------------------------------------------------
package ndpf_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_DIMS   = 8;

  localparam int PT_W   = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int POS_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DIM_W  = $clog2(MAX_DIMS + 1);
  localparam int DEPTH  = MAX_POINTS * MAX_DIMS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int COORD_W     = 16;
  localparam int RADIUS_W    = 16;
  localparam int DIMS_CFG_W  = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int KIDX_W      = 6;
  localparam int OUT_TDATA_W = 8;

  // squarer operand: coordinate difference or radius, both fit in 17 signed bits
  localparam int OP_W  = COORD_W + 1;
  localparam int SQ_W  = 32;
  localparam int ACC_W = SQ_W + $clog2(MAX_DIMS);

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 1'd1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FILL,
    S_R2,
    S_R2W,
    S_SCAN_I,
    S_SCAN_J,
    S_DIST,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic                   valid;
    logic signed [OP_W-1:0] operand;
  } sq_req_t;

  function automatic logic [ADDR_W-1:0] calc_addr(input logic [PT_W-1:0]  pt,
                                                   input logic [POS_W-1:0] pos);
    calc_addr = ADDR_W'(pt) * ADDR_W'(MAX_DIMS) + ADDR_W'(pos);
  endfunction

endpackage
`default_nettype wire

[rtl/ndpf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ndpf_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ndpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

[rtl/ndpf_sq_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ndpf_sq_unit
// Shared squarer: one 17x17 signed square per cycle, registered result.
// ----------------------------------------------------------------------------
module ndpf_sq_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ndpf_pkg::sq_req_t req_i,
  output logic                   sq_valid_o,
  output logic [ndpf_pkg::SQ_W-1:0] sq_o
);
  import ndpf_pkg::*;

  logic signed [2*OP_W-1:0] prod;
  logic                     valid_q;
  logic [SQ_W-1:0]          sq_q;

  // |operand| <= 65535, so the square fits in 32 unsigned bits
  assign prod = req_i.operand * req_i.operand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      sq_q <= prod[SQ_W-1:0];
    end
  end

  assign sq_valid_o = valid_q;
  assign sq_o       = sq_q;

endmodule
`default_nettype wire

[rtl/near_duplicate_point_filter_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// near_duplicate_point_filter_top
// Loads a point set, removes points within radius of a kept point (highest
// index first), then streams the surviving indices in ascending order.
// ----------------------------------------------------------------------------
// Coordinates are taken one per cycle while loading. A point that ends before
// MAX_DIMS coordinates makes the input not ready while the rest of its row in
// the point RAM is zeroed. The transaction with tlast starts the filter: the
// radius is squared (S_R2, S_R2W), then each outer index i and each inner
// index j is visited, and each compared pair is summed one coordinate at a
// time, since one squarer and the two RAM read ports handle one coordinate
// per cycle. Results then leave at up to one per cycle, as output backpressure
// allows, with removed indices skipped in between. The input is not ready from
// the last point until the final result sits in the output register.
// ----------------------------------------------------------------------------
module near_duplicate_point_filter_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [ndpf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ndpf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [ndpf_pkg::COORD_W-1:0]      s_axis_tdata,  // [15:0] coord
  input  wire logic                              s_axis_tuser,  // [0] last_coord
  input  wire logic                              s_axis_tlast,  // last_point
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [ndpf_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // [5:0] kept_index, [7:6] 0
  output logic                                   m_axis_tuser,  // [0] overflow
  output logic                                   m_axis_tlast   // last
);
  import ndpf_pkg::*;

  state_e state_q, state_d;

  logic [RADIUS_W-1:0]   radius_q;
  logic [DIMS_CFG_W-1:0] dims_cfg_q;
  logic [DIM_W-1:0]      dims_act;

  logic [CNT_W-1:0]      pcount_q, pcount_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic                  dropped_q, dropped_d;
  logic [MAX_POINTS-1:0] keep_q, keep_d;
  logic                  scan_pend_q, scan_pend_d;
  logic [PT_W-1:0]       fill_row_q, fill_row_d;
  logic [POS_W-1:0]      fill_pos_q, fill_pos_d;

  logic [SQ_W-1:0]       r2_q, r2_d;
  logic [PT_W-1:0]       i_q, i_d;
  logic [CNT_W-1:0]      j_q, j_d;
  logic [DIM_W-1:0]      iss_k_q, iss_k_d;
  logic                  rd_v_q, rd_v_d;
  logic [ACC_W-1:0]      acc_q, acc_d;

  logic [CNT_W-1:0]      e_q, e_d;
  logic                  have_q, have_d;
  logic [PT_W-1:0]       pend_q, pend_d;

  logic                  out_v_q, out_v_d;
  logic [KIDX_W-1:0]     out_idx_q, out_idx_d;
  logic                  out_last_q, out_last_d;
  logic                  out_ovf_q, out_ovf_d;

  logic                  in_acc;
  logic                  stored;
  logic                  end_pt;
  logic                  out_free;
  logic                  issue;
  logic                  dist_done;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COORD_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]     raddr_a, raddr_b;
  logic [COORD_W-1:0]    rdata_a, rdata_b;
  sq_req_t               sq_req;
  logic                  sq_valid;
  logic [SQ_W-1:0]       sq;
  logic [PT_W-1:0]       j_pt, e_pt;

  ndpf_ram #(
    .WIDTH(COORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  ndpf_sq_unit u_sq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (sq_req),
    .sq_valid_o(sq_valid),
    .sq_o      (sq)
  );

  // dims of 0 acts as 1, above MAX_DIMS saturates
  always_comb begin
    if (dims_cfg_q == '0) begin
      dims_act = DIM_W'(1);
    end else if (32'(dims_cfg_q) > 32'(MAX_DIMS)) begin
      dims_act = DIM_W'(MAX_DIMS);
    end else begin
      dims_act = DIM_W'(dims_cfg_q);
    end
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign stored        = (pcount_q < CNT_W'(MAX_POINTS));
  assign end_pt        = s_axis_tuser || s_axis_tlast ||
                         ((DIM_W'(pos_q) + DIM_W'(1)) >= dims_act);
  assign out_free      = !out_v_q || m_axis_tready;
  assign issue         = (state_q == S_DIST) && (iss_k_q < dims_act);
  assign dist_done     = (state_q == S_DIST) && (iss_k_q == dims_act) &&
                         !rd_v_q && !sq_valid;
  assign j_pt          = j_q[PT_W-1:0];
  assign e_pt          = e_q[PT_W-1:0];

  assign raddr_a = calc_addr(i_q, iss_k_q[POS_W-1:0]);
  assign raddr_b = calc_addr(j_pt, iss_k_q[POS_W-1:0]);

  always_comb begin
    if (state_q == S_R2) begin
      sq_req.valid   = 1'b1;
      sq_req.operand = $signed({1'b0, radius_q});
    end else begin
      sq_req.valid   = rd_v_q;
      sq_req.operand = $signed({rdata_a[COORD_W-1], rdata_a}) -
                       $signed({rdata_b[COORD_W-1], rdata_b});
    end
  end

  always_comb begin
    state_d     = state_q;
    pcount_d    = pcount_q;
    pos_d       = pos_q;
    dropped_d   = dropped_q;
    keep_d      = keep_q;
    scan_pend_d = scan_pend_q;
    fill_row_d  = fill_row_q;
    fill_pos_d  = fill_pos_q;
    r2_d        = r2_q;
    i_d         = i_q;
    j_d         = j_q;
    iss_k_d     = iss_k_q;
    rd_v_d      = issue;
    acc_d       = acc_q;
    e_d         = e_q;
    have_d      = have_q;
    pend_d      = pend_q;
    out_v_d     = out_v_q && !m_axis_tready;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = calc_addr(pcount_q[PT_W-1:0], pos_q);
    ram_wdata   = s_axis_tdata;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (stored) begin
            ram_we = 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (end_pt) begin
            pos_d = '0;
            if (stored) begin
              keep_d[pcount_q[PT_W-1:0]] = 1'b1;
              pcount_d = pcount_q + CNT_W'(1);
            end
            // zero the rest of a short row so missing coordinates read as zero
            if (stored && ((DIM_W'(pos_q) + DIM_W'(1)) < DIM_W'(MAX_DIMS))) begin
              fill_row_d  = pcount_q[PT_W-1:0];
              fill_pos_d  = pos_q + POS_W'(1);
              scan_pend_d = s_axis_tlast;
              state_d     = S_FILL;
            end else if (s_axis_tlast) begin
              state_d = S_R2;
            end
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = calc_addr(fill_row_q, fill_pos_q);
        ram_wdata = '0;
        if (fill_pos_q == POS_W'(MAX_DIMS - 1)) begin
          state_d = scan_pend_q ? S_R2 : S_LOAD;
        end else begin
          fill_pos_d = fill_pos_q + POS_W'(1);
        end
      end

      S_R2: begin
        state_d = S_R2W;
      end

      S_R2W: begin
        r2_d = sq;
        if (pcount_q == '0) begin
          pcount_d  = '0;
          pos_d     = '0;
          dropped_d = 1'b0;
          state_d   = S_LOAD;
        end else begin
          i_d     = PT_W'(pcount_q - CNT_W'(1));
          state_d = S_SCAN_I;
        end
      end

      S_SCAN_I: begin
        if (keep_q[i_q]) begin
          j_d     = '0;
          state_d = S_SCAN_J;
        end else if (i_q == '0) begin
          e_d     = '0;
          have_d  = 1'b0;
          state_d = S_EMIT;
        end else begin
          i_d = i_q - PT_W'(1);
        end
      end

      S_SCAN_J: begin
        if (j_q == pcount_q) begin
          if (i_q == '0) begin
            e_d     = '0;
            have_d  = 1'b0;
            state_d = S_EMIT;
          end else begin
            i_d     = i_q - PT_W'(1);
            state_d = S_SCAN_I;
          end
        end else if ((j_q == CNT_W'(i_q)) || !keep_q[j_pt]) begin
          // already removed points need no compare
          j_d = j_q + CNT_W'(1);
        end else begin
          iss_k_d = '0;
          acc_d   = '0;
          state_d = S_DIST;
        end
      end

      S_DIST: begin
        if (issue) begin
          iss_k_d = iss_k_q + DIM_W'(1);
        end
        if (sq_valid) begin
          acc_d = acc_q + ACC_W'(sq);
        end
        if (dist_done) begin
          if (acc_q <= ACC_W'(r2_q)) begin
            keep_d[j_pt] = 1'b0;
          end
          j_d     = j_q + CNT_W'(1);
          state_d = S_SCAN_J;
        end
      end

      S_EMIT: begin
        // a found index waits in pend until the next one (or the end) tells last
        if (e_q < pcount_q) begin
          if (keep_q[e_pt]) begin
            if (!have_q) begin
              pend_d = e_pt;
              have_d = 1'b1;
              e_d    = e_q + CNT_W'(1);
            end else if (out_free) begin
              out_v_d    = 1'b1;
              out_idx_d  = KIDX_W'(pend_q);
              out_last_d = 1'b0;
              out_ovf_d  = dropped_q;
              pend_d     = e_pt;
              e_d        = e_q + CNT_W'(1);
            end
          end else begin
            e_d = e_q + CNT_W'(1);
          end
        end else if (!have_q || out_free) begin
          if (have_q) begin
            out_v_d    = 1'b1;
            out_idx_d  = KIDX_W'(pend_q);
            out_last_d = 1'b1;
            out_ovf_d  = dropped_q;
            have_d     = 1'b0;
          end
          pcount_d  = '0;
          pos_d     = '0;
          dropped_d = 1'b0;
          state_d   = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      radius_q    <= '0;
      dims_cfg_q  <= DIMS_CFG_W'(1);
      pcount_q    <= '0;
      pos_q       <= '0;
      dropped_q   <= 1'b0;
      keep_q      <= '0;
      scan_pend_q <= 1'b0;
      rd_v_q      <= 1'b0;
      have_q      <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      pcount_q    <= pcount_d;
      pos_q       <= pos_d;
      dropped_q   <= dropped_d;
      keep_q      <= keep_d;
      scan_pend_q <= scan_pend_d;
      rd_v_q      <= rd_v_d;
      have_q      <= have_d;
      out_v_q     <= out_v_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RADIUS: radius_q   <= cfg_data_i[RADIUS_W-1:0];
          CFG_DIMS:   dims_cfg_q <= cfg_data_i[DIMS_CFG_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_row_q <= fill_row_d;
    fill_pos_q <= fill_pos_d;
    r2_q       <= r2_d;
    i_q        <= i_d;
    j_q        <= j_d;
    iss_k_q    <= iss_k_d;
    acc_q      <= acc_d;
    e_q        <= e_d;
    pend_q     <= pend_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_idx_q);
  assign m_axis_tuser  = out_ovf_q;
  assign m_axis_tlast  = out_last_q;

  // point RAM is never written while a distance is being read out
  a_no_write_in_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIST) |-> !ram_we)
    else $error("point RAM written during distance scan");

  // stored point count never passes capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcount_q <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  // a point never compares against itself
  a_pair_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIST) |-> (j_q != CNT_W'(i_q)))
    else $error("distance scan on identical indices");

  // a new result is only loaded when the previous one has been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |=> ($stable(out_idx_q) && $stable(out_last_q)))
    else $error("pending result overwritten");

  // squarer pipeline is drained before a new pair starts
  a_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_J) |-> (!rd_v_q && !sq_valid))
    else $error("squarer busy at pair start");

endmodule
`default_nettype wire
